// ===== rtl/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg: shared types and constants for the perspective projection divide
// Fixed-point format, register indexes and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none
package ppd_pkg;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	// Widths of the magnitude divider: numerator is |v'| * 2^FRAC_BITS.
	localparam int NUM_W     = DATA_W + FRAC_BITS;
	localparam int SUM_W     = 2 * DATA_W + 2;
	localparam int IDX_W     = 3;

	localparam logic signed [DATA_W-1:0] ONE_FX    = DATA_W'(1) << FRAC_BITS;
	localparam logic signed [DATA_W-1:0] DEPTH_RST = -(DATA_W'(2) << FRAC_BITS);
	localparam logic signed [DATA_W-1:0] S32_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] S32_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [IDX_W-1:0] {
		REG_X_SCALE      = 3'd0,
		REG_X_SKEW       = 3'd1,
		REG_Y_SCALE      = 3'd2,
		REG_Y_SKEW       = 3'd3,
		REG_DEPTH_OFFSET = 3'd4
	} reg_idx_t;

	typedef logic signed [DATA_W-1:0] fx_t;

	function automatic fx_t sat_s32(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(S32_MAX))
			return S32_MAX;
		else if (v < SUM_W'(S32_MIN))
			return S32_MIN;
		else
			return v[DATA_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/perspective_projection_divide.sv =====
// ----------------------------------------------------------------------------
// perspective_projection_divide
// Sparse perspective matrix followed by the homogeneous divide by w'.
// Data is signed Q16.16; the divide is a restoring divider
// that resolves one quotient bit per stage.
// Throughput: one vertex per cycle; a stalled output freezes the whole pipe.
// Reset: arst_n clears all valid bits and loads the matrix register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module perspective_projection_divide (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [ppd_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [ppd_pkg::DATA_W-1:0]   cfg_data,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [4*ppd_pkg::DATA_W-1:0] s_tdata,  // x_in, y_in, z_in, w_in
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [4*ppd_pkg::DATA_W-1:0]      m_tdata,  // x_out, y_out, z_out, w_out
	output logic [0:0]                        m_tuser   // zero_w
);
	import ppd_pkg::*;

	fx_t x_scale_q, x_skew_q, y_scale_q, y_skew_q, depth_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q      <= ONE_FX;
			x_skew_q       <= '0;
			y_scale_q      <= ONE_FX;
			y_skew_q       <= '0;
			depth_offset_q <= DEPTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_SCALE:      x_scale_q      <= cfg_data;
				REG_X_SKEW:       x_skew_q       <= cfg_data;
				REG_Y_SCALE:      y_scale_q      <= cfg_data;
				REG_Y_SKEW:       y_skew_q       <= cfg_data;
				REG_DEPTH_OFFSET: depth_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic out_valid_q;
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	fx_t x_in, y_in, z_in, w_in;
	assign x_in = s_tdata[DATA_W-1:0];
	assign y_in = s_tdata[2*DATA_W-1:DATA_W];
	assign z_in = s_tdata[3*DATA_W-1:2*DATA_W];
	assign w_in = s_tdata[4*DATA_W-1:3*DATA_W];

	// Stage 1: the five products.
	logic                          v_s1;
	logic signed [2*DATA_W-1:0]    px0_s1, px1_s1, py0_s1, py1_s1, pz_s1;
	fx_t                           z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px0_s1 <= x_scale_q * x_in;
			px1_s1 <= x_skew_q * z_in;
			py0_s1 <= y_scale_q * y_in;
			py1_s1 <= y_skew_q * z_in;
			pz_s1  <= depth_offset_q * w_in;
			z_s1   <= z_in;
		end
	end

	// Stage 2: row sums, floor shift and saturation.
	logic                   v_s2;
	fx_t                    xp_s2, yp_s2, zp_s2, wp_s2;
	logic signed [SUM_W-1:0] sum_x, sum_y, sum_z, neg_z;

	always_comb begin
		sum_x = (SUM_W'(px0_s1) + SUM_W'(px1_s1)) >>> FRAC_BITS;
		sum_y = (SUM_W'(py0_s1) + SUM_W'(py1_s1)) >>> FRAC_BITS;
		neg_z = -SUM_W'(z_s1);
		sum_z = (SUM_W'(pz_s1) >>> FRAC_BITS) + neg_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s2 <= sat_s32(sum_x);
			yp_s2 <= sat_s32(sum_y);
			zp_s2 <= sat_s32(sum_z);
			wp_s2 <= sat_s32(neg_z);
		end
	end

	// Divider stages: index 0 is loaded with magnitudes and signs, each later
	// index holds one more quotient bit. Lanes are x, y, z.
	logic                   v_sd    [0:NUM_W];
	logic [DATA_W-1:0]      rem_sd  [0:NUM_W][0:2];
	logic [NUM_W-1:0]       nq_sd   [0:NUM_W][0:2];
	logic [2:0]             neg_sd  [0:NUM_W];
	logic [DATA_W-1:0]      d_sd    [0:NUM_W];
	fx_t                    wp_sd   [0:NUM_W];
	logic                   zero_sd [0:NUM_W];

	fx_t               lane_v [0:2];
	logic [DATA_W-1:0] d_mag;
	assign lane_v[0] = xp_s2;
	assign lane_v[1] = yp_s2;
	assign lane_v[2] = zp_s2;
	assign d_mag     = wp_s2[DATA_W-1] ? DATA_W'(-wp_s2) : DATA_W'(wp_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sd[0] <= 1'b0;
		else if (en)
			v_sd[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rem_sd[0][l] <= '0;
				nq_sd[0][l]  <= {(lane_v[l][DATA_W-1] ? DATA_W'(-lane_v[l])
					: DATA_W'(lane_v[l])), {FRAC_BITS{1'b0}}};
				neg_sd[0][l] <= lane_v[l][DATA_W-1] ^ wp_s2[DATA_W-1];
			end
			d_sd[0]    <= d_mag;
			wp_sd[0]   <= wp_s2;
			zero_sd[0] <= (wp_s2 == '0);
		end
	end

	for (genvar k = 0; k < NUM_W; k++) begin : g_div
		logic [DATA_W:0] shl  [0:2];
		logic [DATA_W:0] diff [0:2];

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				shl[l]  = {rem_sd[k][l], nq_sd[k][l][NUM_W-1]};
				diff[l] = shl[l] - {1'b0, d_sd[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sd[k+1] <= 1'b0;
			else if (en)
				v_sd[k+1] <= v_sd[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					rem_sd[k+1][l] <= diff[l][DATA_W] ? shl[l][DATA_W-1:0]
						: diff[l][DATA_W-1:0];
					nq_sd[k+1][l]  <= {nq_sd[k][l][NUM_W-2:0], ~diff[l][DATA_W]};
				end
				neg_sd[k+1]  <= neg_sd[k];
				d_sd[k+1]    <= d_sd[k];
				wp_sd[k+1]   <= wp_sd[k];
				zero_sd[k+1] <= zero_sd[k];
			end
		end
	end

	// Output stage: restore the sign and saturate; a zero w' clears the results.
	fx_t q_res [0:2];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (zero_sd[NUM_W])
				q_res[l] = '0;
			else if (neg_sd[NUM_W][l])
				q_res[l] = (nq_sd[NUM_W][l] > NUM_W'({1'b0, S32_MIN})) ? S32_MIN
					: DATA_W'(-nq_sd[NUM_W][l]);
			else
				q_res[l] = (nq_sd[NUM_W][l] > NUM_W'(S32_MAX)) ? S32_MAX
					: nq_sd[NUM_W][l][DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= v_sd[NUM_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {(zero_sd[NUM_W] ? '0 : wp_sd[NUM_W]), q_res[2], q_res[1], q_res[0]};
			m_tuser <= zero_sd[NUM_W];
		end
	end

	assign m_tvalid = out_valid_q;
endmodule
`default_nettype wire

// ===== rtl/ppd_check.sv =====
// ----------------------------------------------------------------------------
// ppd_check: port-level checks for perspective_projection_divide
// Watches the stream ports and flags illegal output behavior and input stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module ppd_check (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_tready,
	input wire logic                         m_tvalid,
	input wire logic                         m_tready,
	input wire logic [4*ppd_pkg::DATA_W-1:0] m_tdata,
	input wire logic [0:0]                   m_tuser
);
	import ppd_pkg::*;

	// A beat held back by the sink must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// A zero divisor clears every coordinate.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("zero_w beat carries nonzero data");

	// Without the flag, w' must be nonzero.
	a_wnz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[4*DATA_W-1:3*DATA_W] != '0)
		else $error("zero w' without zero_w");

	// The input side only stalls while a finished beat waits.
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with output free");
endmodule

bind perspective_projection_divide ppd_check u_ppd_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== verif/tb_perspective_projection_divide.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for perspective_projection_divide
// Drives vertices through the projection and divide with random gaps on both
// stream sides, predicts each output beat in fixed point and checks it in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_perspective_projection_divide;
	import ppd_pkg::*;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] w;
		logic        zw;
	} vtx_out_t;

	localparam int LATENCY = NUM_W + 4;

	int errors = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	class projection_scoreboard;
		logic signed [31:0] mat [5];
		vtx_out_t pending [$];
		int n_in, n_out, n_zero;

		function void reset_matrix();
			mat[REG_X_SCALE] = ONE_FX;
			mat[REG_X_SKEW] = 0;
			mat[REG_Y_SCALE] = ONE_FX;
			mat[REG_Y_SKEW] = 0;
			mat[REG_DEPTH_OFFSET] = DEPTH_RST;
		endfunction

		function logic signed [31:0] clamp(input logic signed [71:0] v);
			if (v > 72'sd2147483647) return 32'sh7fffffff;
			if (v < -72'sd2147483648) return 32'sh80000000;
			return v[31:0];
		endfunction

		function logic signed [31:0] quotient(input logic signed [31:0] num,
				input logic signed [31:0] den);
			logic signed [71:0] n, d;
			n = 72'(num) <<< FRAC_BITS;
			d = 72'(den);
			return clamp(n / d);
		endfunction

		function void note_vertex(input logic [127:0] d);
			logic signed [31:0] x, y, z, w, xp, yp, zp, wp;
			logic signed [71:0] s;
			vtx_out_t r;
			x = d[31:0]; y = d[63:32]; z = d[95:64]; w = d[127:96];
			// Arithmetic shift of the exact sum rounds toward minus infinity.
			s = (72'(mat[REG_X_SCALE]) * 72'(x) + 72'(mat[REG_X_SKEW]) * 72'(z))
				>>> FRAC_BITS;
			xp = clamp(s);
			s = (72'(mat[REG_Y_SCALE]) * 72'(y) + 72'(mat[REG_Y_SKEW]) * 72'(z))
				>>> FRAC_BITS;
			yp = clamp(s);
			s = -72'(z) + ((72'(mat[REG_DEPTH_OFFSET]) * 72'(w)) >>> FRAC_BITS);
			zp = clamp(s);
			wp = clamp(-72'(z));
			if (wp == 0) begin
				r = '0;
				r.zw = 1'b1;
			end else begin
				r.x = quotient(xp, wp);
				r.y = quotient(yp, wp);
				r.z = quotient(zp, wp);
				r.w = wp;
				r.zw = 1'b0;
			end
			pending.push_back(r);
			n_in++;
		endfunction

		task check_result(input logic [127:0] d, input logic zw);
			vtx_out_t e;
			if (pending.size() == 0) begin
				report_mismatch("unexpected beat", d[31:0], '0);
				return;
			end
			e = pending.pop_front();
			n_out++;
			if (zw) n_zero++;
			if (d[31:0] !== e.x) report_mismatch("x_out", d[31:0], e.x);
			if (d[63:32] !== e.y) report_mismatch("y_out", d[63:32], e.y);
			if (d[95:64] !== e.z) report_mismatch("z_out", d[95:64], e.z);
			if (d[127:96] !== e.w) report_mismatch("w_out", d[127:96], e.w);
			if (zw !== e.zw) report_mismatch("zero_w", 32'(zw), 32'(e.zw));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [127:0] m_tdata;
	logic [0:0] m_tuser;

	bit hold_sink = 0;

	projection_scoreboard sb = new();

	perspective_projection_divide u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h00000000;
			3: return 32'hffffffff;
			4: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
			5: return 32'(1 << 16);
			default: return $urandom();
		endcase
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.mat[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_vertex(input logic [31:0] x, y, z, w);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {w, z, y, x};
		do @(posedge clk); while (!s_tready);
		sb.note_vertex({w, z, y, x});
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic random_phase(input int n);
		logic [31:0] z;
		for (int i = 0; i < n; i++) begin
			z = rand_word();
			// A handful of vertices sit on the w' = 0 plane.
			if ($urandom_range(0, 19) == 0) z = 0;
			send_vertex(rand_word(), rand_word(), z, rand_word());
		end
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser[0]);
	end

	// Sink side: random stalls, plus one long hold-off to back the pipe up.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				m_tready <= 1'b0;
				repeat (150) @(negedge clk);
				hold_sink = 0;
			end
			g = gap_len();
			if (g > 0 && $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		sb.reset_matrix();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed vertices at the default matrix.
		send_vertex(32'h00010000, 32'h00010000, 32'hfffe0000, 32'h00010000);
		send_vertex(32'h7fffffff, 32'h80000000, 32'h00000001, 32'h7fffffff);
		send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000);
		send_vertex(32'h12345678, 32'hedcba987, 32'h00000000, 32'h00010000);
		send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_vertex(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		send_vertex(32'h00000000, 32'h00000000, 32'h00000001, 32'h00000000);
		send_vertex(32'hfffffffd, 32'h00000003, 32'h00000002, 32'hffffffff);
		wait_drained();

		// Extreme matrix: products that saturate and skew terms.
		write_reg(REG_X_SCALE, 32'h7fffffff);
		write_reg(REG_X_SKEW, 32'h80000000);
		write_reg(REG_Y_SCALE, 32'h80000000);
		write_reg(REG_Y_SKEW, 32'h7fffffff);
		write_reg(REG_DEPTH_OFFSET, 32'h7fffffff);
		send_vertex(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
		send_vertex(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
		send_vertex(32'h00000001, 32'hffffffff, 32'hffffffff, 32'h00000001);
		send_vertex(32'h00010000, 32'h00010000, 32'h00000000, 32'h00010000);
		random_phase(150);
		wait_drained();

		write_reg(REG_X_SCALE, 32'h0);
		write_reg(REG_X_SKEW, 32'h0);
		write_reg(REG_Y_SCALE, 32'h0);
		write_reg(REG_Y_SKEW, 32'h0);
		write_reg(REG_DEPTH_OFFSET, 32'h80000000);
		random_phase(100);
		wait_drained();

		// Typical frustum values, with the long sink hold-off.
		write_reg(REG_X_SCALE, 32'h0001a000);
		write_reg(REG_X_SKEW, 32'hffff8000);
		write_reg(REG_Y_SCALE, 32'h00020000);
		write_reg(REG_Y_SKEW, 32'h00004000);
		write_reg(REG_DEPTH_OFFSET, 32'hfffe0000);
		hold_sink = 1;
		random_phase(250);
		wait_drained();

		for (int k = 0; k < 3; k++) begin
			write_reg(REG_X_SCALE, $urandom());
			write_reg(REG_X_SKEW, $urandom());
			write_reg(REG_Y_SCALE, $urandom());
			write_reg(REG_Y_SKEW, $urandom());
			write_reg(REG_DEPTH_OFFSET, $urandom());
			random_phase(100);
			wait_drained();
		end

		$display("Covered %0d vertices, %0d results, %0d with w' zero, seven matrix settings.",
			sb.n_in, sb.n_out, sb.n_zero);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/ppd_pkg.sv
rtl/perspective_projection_divide.sv
rtl/ppd_check.sv
verif/tb_perspective_projection_divide.sv
